>>> rtl/cfsc_pkg.sv
// Shared constants and operation codes for the crossfade slot controller.
package cfsc_pkg;

  // Default width of a stored source id.
  localparam int ID_BITS_DEF = 16;

  // Width of the id, blend, rate and elapsed fields on the ports.
  localparam int PORT_ID_W = 16;
  localparam int BLEND_W   = 17;
  localparam int RATE_W    = 16;
  localparam int ELAP_W    = 16;

  // Blend arithmetic is done in a signed word wide enough for the largest decrement.
  localparam int DEC_W = RATE_W + ELAP_W - 8;
  localparam int ACC_W = DEC_W + 2;

  // Blend of 1.0 in Q1.16.
  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

  // Fade rate limits in Q8.8.
  localparam logic [RATE_W-1:0] RATE_MIN   = 16'd26;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

  // Operation codes carried by the mode field.
  localparam logic [1:0] MODE_FADE_TO  = 2'd0;
  localparam logic [1:0] MODE_DROP     = 2'd1;
  localparam logic [1:0] MODE_DROP_ALL = 2'd2;
  localparam logic [1:0] MODE_TICK     = 2'd3;

endpackage

>>> rtl/crossfade_slot_controller_core.sv
// A result is registered: a beat passes the input register, then the result register.
// One beat per cycle unless the result register stalls; the input register refills
// in the same cycle that it hands its item to the result register.
// The path from the input register to the result register holds one 16x16 multiply.
// Reset (synchronous, active high) empties all slots, sets the blend to 1.0,
// the fade rate to 1.0 per second, and drops both valid flags.
module crossfade_slot_controller_core #(
  parameter int ID_BITS = cfsc_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [cfsc_pkg::RATE_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [cfsc_pkg::PORT_ID_W-1:0] map_id,
  input  logic [cfsc_pkg::ELAP_W-1:0]    elapsed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cfsc_pkg::PORT_ID_W-1:0] active_id,
  output logic [cfsc_pkg::PORT_ID_W-1:0] fading_id,
  output logic [cfsc_pkg::PORT_ID_W-1:0] pending_id,
  output logic [cfsc_pkg::BLEND_W-1:0]   blend,
  output logic                           is_fading,
  output logic                           bad_drop
);
  import cfsc_pkg::*;

  localparam int EXT_W = ID_BITS + PORT_ID_W;

  logic [RATE_W-1:0]  rate;
  logic               in_valid_q;
  logic [1:0]         mode_q;
  logic [ID_BITS-1:0] id_q;
  logic [ELAP_W-1:0]  elapsed_q;
  logic [EXT_W-1:0]   id_ext;
  logic               advance;

  logic [ID_BITS-1:0] active;
  logic [ID_BITS-1:0] fading;
  logic [ID_BITS-1:0] pending;
  logic [BLEND_W-1:0] blend_level;

  logic [ID_BITS-1:0] active_next;
  logic [ID_BITS-1:0] fading_next;
  logic [ID_BITS-1:0] pending_next;
  logic [BLEND_W-1:0] blend_next;
  logic               bad_next;
  logic [EXT_W-1:0]   active_ext;
  logic [EXT_W-1:0]   fading_ext;
  logic [EXT_W-1:0]   pending_ext;

  cfsc_rate_reg u_rate (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_wr_en),
    .wr_data (cfg_wr_data),
    .rate    (rate)
  );

  // Handshake: the item moves on whenever the result register is free or being emptied.
  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;

  // The incoming id is cut to the stored id width.
  assign id_ext = {{ID_BITS{1'b0}}, map_id};

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q    <= mode;
      id_q      <= id_ext[ID_BITS-1:0];
      elapsed_q <= elapsed;
    end
  end

  cfsc_slot_update #(
    .ID_BITS (ID_BITS)
  ) u_update (
    .mode         (mode_q),
    .id           (id_q),
    .elapsed      (elapsed_q),
    .rate         (rate),
    .active       (active),
    .fading       (fading),
    .pending      (pending),
    .blend        (blend_level),
    .active_next  (active_next),
    .fading_next  (fading_next),
    .pending_next (pending_next),
    .blend_next   (blend_next),
    .bad_next     (bad_next)
  );

  // Slot state is committed as the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      fading      <= '0;
      pending     <= '0;
      blend_level <= BLEND_ONE;
    end else if (advance) begin
      active      <= active_next;
      fading      <= fading_next;
      pending     <= pending_next;
      blend_level <= blend_next;
    end
  end

  // Ids are shown on the ports at the port width.
  assign active_ext  = {{PORT_ID_W{1'b0}}, active_next};
  assign fading_ext  = {{PORT_ID_W{1'b0}}, fading_next};
  assign pending_ext = {{PORT_ID_W{1'b0}}, pending_next};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      active_id  <= active_ext[PORT_ID_W-1:0];
      fading_id  <= fading_ext[PORT_ID_W-1:0];
      pending_id <= pending_ext[PORT_ID_W-1:0];
      blend      <= blend_next;
      is_fading  <= (fading_next != '0);
      bad_drop   <= bad_next;
    end
  end

endmodule

>>> rtl/cfsc_rate_reg.sv
// Fade rate configuration register with the lower clamp applied on write.
module cfsc_rate_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [cfsc_pkg::RATE_W-1:0] wr_data,
  output logic [cfsc_pkg::RATE_W-1:0] rate
);
  import cfsc_pkg::*;

  logic [RATE_W-1:0] rate_next;

  // Rates below the minimum are raised to it.
  always_comb begin
    rate_next = (wr_data < RATE_MIN) ? RATE_MIN : wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (wr_en) begin
      rate <= rate_next;
    end
  end

endmodule

>>> rtl/cfsc_slot_update.sv
// Next-state logic for the slots and blend level for one operation.
module cfsc_slot_update #(
  parameter int ID_BITS = cfsc_pkg::ID_BITS_DEF
) (
  input  logic [1:0]                     mode,
  input  logic [ID_BITS-1:0]             id,
  input  logic [cfsc_pkg::ELAP_W-1:0]    elapsed,
  input  logic [cfsc_pkg::RATE_W-1:0]    rate,
  input  logic [ID_BITS-1:0]             active,
  input  logic [ID_BITS-1:0]             fading,
  input  logic [ID_BITS-1:0]             pending,
  input  logic [cfsc_pkg::BLEND_W-1:0]   blend,
  output logic [ID_BITS-1:0]             active_next,
  output logic [ID_BITS-1:0]             fading_next,
  output logic [ID_BITS-1:0]             pending_next,
  output logic [cfsc_pkg::BLEND_W-1:0]   blend_next,
  output logic                           bad_next
);
  import cfsc_pkg::*;

  logic [RATE_W+ELAP_W-1:0] product;
  logic [DEC_W-1:0]         dec;
  logic signed [ACC_W-1:0]  acc0;
  logic signed [ACC_W-1:0]  acc1;
  logic                     promote0;
  logic                     promote1;

  // Tick arithmetic: one multiply, then the subtraction and the promotion tests.
  always_comb begin
    product  = rate * elapsed;
    dec      = product[RATE_W+ELAP_W-1:8];
    acc0     = $signed({{(ACC_W-BLEND_W){1'b0}}, blend}) - $signed({2'b00, dec});
    promote0 = acc0[ACC_W-1] || (acc0 == '0);
    acc1     = acc0 + $signed({{(ACC_W-BLEND_W){1'b0}}, BLEND_ONE});
    promote1 = promote0 && (pending != '0) && (acc1[ACC_W-1] || (acc1 == '0));
  end

  // Operation decode; the drop cases are applied in order as later ones see earlier ones.
  always_comb begin
    active_next  = active;
    fading_next  = fading;
    pending_next = pending;
    blend_next   = blend;
    bad_next     = 1'b0;
    case (mode)
      MODE_FADE_TO: begin
        if (id == active) begin
          active_next = active;
        end else if (active == '0) begin
          active_next = id;
        end else if (fading == '0) begin
          fading_next = id;
        end else if (id == fading) begin
          pending_next = '0;
        end else begin
          pending_next = id;
        end
      end
      MODE_DROP: begin
        if (id == '0) begin
          bad_next = 1'b1;
        end else begin
          if (pending_next == id) begin
            pending_next = '0;
          end
          if (fading_next == id) begin
            fading_next  = pending_next;
            pending_next = '0;
            blend_next   = BLEND_ONE;
          end
          if (active_next == id) begin
            active_next  = fading_next;
            fading_next  = pending_next;
            pending_next = '0;
            blend_next   = BLEND_ONE;
          end
        end
      end
      MODE_DROP_ALL: begin
        active_next  = '0;
        fading_next  = '0;
        pending_next = '0;
        blend_next   = BLEND_ONE;
      end
      MODE_TICK: begin
        if (fading != '0) begin
          if (!promote0) begin
            blend_next = acc0[BLEND_W-1:0];
          end else if (promote1) begin
            // Two promotions: the old pending source ends up active with nothing behind it.
            active_next  = pending;
            fading_next  = '0;
            pending_next = '0;
            blend_next   = BLEND_ONE;
          end else begin
            active_next  = fading;
            fading_next  = pending;
            pending_next = '0;
            blend_next   = (pending != '0) ? acc1[BLEND_W-1:0] : BLEND_ONE;
          end
        end
      end
      default: begin
        bad_next = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/cfsc_checker.sv
// Port-level checks for the crossfade slot controller, bound to the top level.
module cfsc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cfsc_pkg::PORT_ID_W-1:0] active_id,
  input logic [cfsc_pkg::PORT_ID_W-1:0] fading_id,
  input logic [cfsc_pkg::PORT_ID_W-1:0] pending_id,
  input logic [cfsc_pkg::BLEND_W-1:0]   blend,
  input logic                           is_fading
);
  import cfsc_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(active_id) && $stable(blend)
      && $stable(fading_id) && $stable(pending_id))
    else $error("result beat changed while stalled");

  // The fading flag follows the fading slot.
  a_fading_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_fading == (fading_id != '0))
    else $error("is_fading disagrees with fading_id");

  // The blend after any operation lies above zero and at most 1.0.
  a_blend_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (blend != '0) && (blend <= BLEND_ONE))
    else $error("blend out of range");

  // Slots fill in order: no pending source without a fading one, none fading without an active.
  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fading_id == '0 || active_id != '0) && (pending_id == '0 || fading_id != '0))
    else $error("slots out of order");

endmodule

bind crossfade_slot_controller_core cfsc_checker u_cfsc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .active_id  (active_id),
  .fading_id  (fading_id),
  .pending_id (pending_id),
  .blend      (blend),
  .is_fading  (is_fading)
);
